// ===== rtl/cif_pkg.sv =====
package cif_pkg;

  localparam int DEF_SECTIONS = 8;
  localparam int DEF_TAPS     = 8;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 24;
  localparam int OPA_W     = 25;
  localparam int PROD_W    = 49;
  localparam int ACC_W     = 64;
  localparam int MID_W     = 40;
  localparam int FRAC_SH   = 20;
  localparam int CNT_REG_W = 4;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 1;
  localparam int CFG_INDEX_W = 2;

  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  localparam logic [1:0] KIND_FF    = 2'd0;
  localparam logic [1:0] KIND_FB    = 2'd1;
  localparam logic [1:0] KIND_RECIP = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_NUM_SECTIONS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FF_TAPS      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FB_TAPS      = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_FF,
    ST_FB,
    ST_DRAIN,
    ST_ROUND1,
    ST_SCALE_LO,
    ST_SCALE_HI,
    ST_DRAIN2,
    ST_ROUND2,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    SEL_FF,
    SEL_FB,
    SEL_LO,
    SEL_HI
  } sel_t;

  typedef struct packed {
    logic valid;
    logic clear;
    logic neg;
    logic shl;
  } mac_op_t;

  typedef struct packed {
    mac_op_t op;
    sel_t    sel;
  } tag_t;

  typedef struct packed {
    logic [CNT_REG_W-1:0] num_sections;
    logic [CNT_REG_W-1:0] ff_taps;
    logic [CNT_REG_W-1:0] fb_taps;
  } cfg_t;

  typedef struct packed {
    logic signed [MID_W-1:0]    mid;
    logic                       mid_sat;
    logic signed [SAMPLE_W-1:0] y;
    logic                       y_sat;
  } rnd_t;

endpackage

// ===== rtl/cif_mac.sv =====
module cif_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  cif_pkg::mac_op_t                    op,
  input  logic signed [cif_pkg::OPA_W-1:0]    opa,
  input  logic signed [cif_pkg::COEF_W-1:0]   opb,
  output cif_pkg::rnd_t                       rnd
);
  import cif_pkg::*;

  localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(64'sd524288);
  localparam int RND_W = ACC_W - FRAC_SH;
  localparam logic signed [RND_W-1:0] MID_HI = RND_W'(44'sd549755813887);
  localparam logic signed [RND_W-1:0] MID_LO = RND_W'(-44'sd549755813888);
  localparam logic signed [RND_W-1:0] Y_HI   = RND_W'(44'sd8388607);
  localparam logic signed [RND_W-1:0] Y_LO   = RND_W'(-44'sd8388608);

  mac_op_t                   op_q;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   rsum;
  logic signed [RND_W-1:0]   rval;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= '0;
    end else begin
      op_q <= op;
    end
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    if (op_q.valid) begin
      acc <= (op_q.clear ? '0 : acc) + term;
    end
  end

  always_comb begin
    term = ACC_W'(prod);
    if (op_q.shl) begin
      term = term <<< FRAC_SH;
    end
    if (op_q.neg) begin
      term = -term;
    end
  end

  // round half up, floor shift back to Q.23
  assign rsum = acc + BIAS;
  assign rval = $signed(rsum[ACC_W-1:FRAC_SH]);

  always_comb begin
    rnd.mid_sat = 1'b0;
    rnd.y_sat   = 1'b0;
    if (rval > MID_HI) begin
      rnd.mid     = MID_HI[MID_W-1:0];
      rnd.mid_sat = 1'b1;
    end else if (rval < MID_LO) begin
      rnd.mid     = MID_LO[MID_W-1:0];
      rnd.mid_sat = 1'b1;
    end else begin
      rnd.mid = rval[MID_W-1:0];
    end
    if (rval > Y_HI) begin
      rnd.y     = Y_HI[SAMPLE_W-1:0];
      rnd.y_sat = 1'b1;
    end else if (rval < Y_LO) begin
      rnd.y     = Y_LO[SAMPLE_W-1:0];
      rnd.y_sat = 1'b1;
    end else begin
      rnd.y = rval[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== rtl/cif_ctrl.sv =====
module cif_ctrl #(
  parameter int SECTIONS = cif_pkg::DEF_SECTIONS,
  parameter int TAPS     = cif_pkg::DEF_TAPS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cif_pkg::cfg_t                        cfg,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic                                 func,
  input  logic signed [cif_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic [1:0]                           coef_kind,
  input  logic [2:0]                           coef_section,
  input  logic [2:0]                           coef_index,
  input  logic signed [cif_pkg::COEF_W-1:0]    coef_value,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic signed [cif_pkg::SAMPLE_W-1:0]  filtered_sample,
  output logic                                 saturated,
  output cif_pkg::mac_op_t                     mac_op,
  output logic signed [cif_pkg::OPA_W-1:0]     mac_a,
  output logic signed [cif_pkg::COEF_W-1:0]    mac_b,
  input  cif_pkg::rnd_t                        rnd
);
  import cif_pkg::*;

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int TAP_W = $clog2(TAPS);
  localparam int AW    = SEC_W + TAP_W;
  localparam int DEPTH = 2 ** AW;
  localparam int SCW   = ($clog2(SECTIONS + 1) > CNT_REG_W) ? $clog2(SECTIONS + 1) : CNT_REG_W;
  localparam int TCW   = ($clog2(TAPS + 1) > CNT_REG_W) ? $clog2(TAPS + 1) : CNT_REG_W;

  state_t state, state_next;
  tag_t   tag_issue, tag_q;

  logic [SCW-1:0] ns_n;
  logic [TCW-1:0] ff_n, fb_n;

  logic [SEC_W-1:0] sec;
  logic [TAP_W-1:0] k;
  logic [TAP_W-1:0] cur_ptr;
  logic [TAP_W-1:0] ptr_new;
  logic [TAP_W-1:0] ptr [SECTIONS];
  logic             wcnt;
  logic [AW-1:0]    clr_cnt;

  logic signed [COEF_W-1:0]   recip [SECTIONS];
  logic signed [SAMPLE_W-1:0] stage_x;
  logic                       sat_acc;
  logic signed [MID_W-1:0]    mid_q;

  logic signed [SAMPLE_W-1:0] xhist [DEPTH];
  logic signed [SAMPLE_W-1:0] yhist [DEPTH];
  logic signed [COEF_W-1:0]   bmem  [DEPTH];
  logic signed [COEF_W-1:0]   amem  [DEPTH];
  logic signed [SAMPLE_W-1:0] x_rd, y_rd;
  logic signed [COEF_W-1:0]   b_rd, a_rd;

  logic [AW-1:0] coef_raddr, hist_raddr, coef_waddr;
  logic          k_last_ff, k_last_fb, sec_last;
  logic          accept, filt_acc, coef_acc, sec_ok, idx_ok;
  logic          out_load;

  // clamp counts to 1..max
  always_comb begin
    if (cfg.num_sections == '0) begin
      ns_n = SCW'(1);
    end else if (SCW'(cfg.num_sections) > SCW'(SECTIONS)) begin
      ns_n = SCW'(SECTIONS);
    end else begin
      ns_n = SCW'(cfg.num_sections);
    end
    if (cfg.ff_taps == '0) begin
      ff_n = TCW'(1);
    end else if (TCW'(cfg.ff_taps) > TCW'(TAPS)) begin
      ff_n = TCW'(TAPS);
    end else begin
      ff_n = TCW'(cfg.ff_taps);
    end
    if (cfg.fb_taps == '0) begin
      fb_n = TCW'(1);
    end else if (TCW'(cfg.fb_taps) > TCW'(TAPS)) begin
      fb_n = TCW'(TAPS);
    end else begin
      fb_n = TCW'(cfg.fb_taps);
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign filt_acc  = accept && (func == FUNC_FILTER);
  assign coef_acc  = accept && (func == FUNC_COEF);
  assign sec_ok    = {29'd0, coef_section} < 32'(SECTIONS);
  assign idx_ok    = {29'd0, coef_index} < 32'(TAPS);
  assign coef_waddr = {SEC_W'(coef_section), TAP_W'(coef_index)};

  assign k_last_ff = (TCW'(k) == ff_n - TCW'(1));
  assign k_last_fb = (TCW'(k) == fb_n - TCW'(1));
  assign sec_last  = (SCW'(sec) == ns_n - SCW'(1));
  assign out_load  = (state == ST_FINISH) && (!m_tvalid || m_tready);

  assign ptr_new    = ptr[sec] - TAP_W'(1);
  assign coef_raddr = {sec, k};
  assign hist_raddr = {sec, TAP_W'(cur_ptr + k)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tag_issue  = '0;
    tag_issue.sel = SEL_FF;
    case (state)
      ST_CLEAR: begin
        if (&clr_cnt) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid && func == FUNC_FILTER) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_FF;
      end
      ST_FF: begin
        tag_issue.op.valid = 1'b1;
        tag_issue.op.clear = (k == '0);
        tag_issue.sel      = SEL_FF;
        if (k_last_ff) begin
          state_next = (fb_n != TCW'(1)) ? ST_FB : ST_DRAIN;
        end
      end
      ST_FB: begin
        tag_issue.op.valid = 1'b1;
        tag_issue.op.neg   = 1'b1;
        tag_issue.sel      = SEL_FB;
        if (k_last_fb) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (wcnt) begin
          state_next = ST_ROUND1;
        end
      end
      ST_ROUND1: begin
        state_next = ST_SCALE_LO;
      end
      ST_SCALE_LO: begin
        tag_issue.op.valid = 1'b1;
        tag_issue.op.clear = 1'b1;
        tag_issue.sel      = SEL_LO;
        state_next         = ST_SCALE_HI;
      end
      ST_SCALE_HI: begin
        tag_issue.op.valid = 1'b1;
        tag_issue.op.shl   = 1'b1;
        tag_issue.sel      = SEL_HI;
        state_next         = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        if (wcnt) begin
          state_next = ST_ROUND2;
        end
      end
      ST_ROUND2: begin
        state_next = sec_last ? ST_FINISH : ST_LOAD;
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      sec      <= '0;
      k        <= '0;
      cur_ptr  <= '0;
      wcnt     <= 1'b0;
      tag_q    <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < SECTIONS; i++) begin
        ptr[i]   <= '0;
        recip[i] <= '0;
      end
    end else begin
      tag_q <= tag_issue;
      wcnt  <= (state == ST_DRAIN || state == ST_DRAIN2) ? ~wcnt : 1'b0;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == ST_IDLE) begin
        sec <= '0;
      end else if (state == ST_ROUND2 && !sec_last) begin
        sec <= sec + SEC_W'(1);
      end
      if (state == ST_LOAD) begin
        k            <= '0;
        cur_ptr      <= ptr_new;
        ptr[sec]     <= ptr_new;
      end else if (state == ST_FF) begin
        k <= k_last_ff ? TAP_W'(1) : k + TAP_W'(1);
      end else if (state == ST_FB) begin
        k <= k + TAP_W'(1);
      end
      if (coef_acc && sec_ok && coef_kind == KIND_RECIP) begin
        recip[SEC_W'(coef_section)] <= coef_value;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (filt_acc) begin
      stage_x <= sample_in;
      sat_acc <= 1'b0;
    end else if (state == ST_ROUND1) begin
      mid_q   <= rnd.mid;
      sat_acc <= sat_acc | rnd.mid_sat;
    end else if (state == ST_ROUND2) begin
      stage_x <= rnd.y;
      sat_acc <= sat_acc | rnd.y_sat;
    end
    if (out_load) begin
      filtered_sample <= stage_x;
      saturated       <= sat_acc;
    end
  end

  // history and coefficient memories
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      xhist[clr_cnt] <= '0;
    end else if (state == ST_LOAD) begin
      xhist[{sec, ptr_new}] <= stage_x;
    end
    x_rd <= xhist[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      yhist[clr_cnt] <= '0;
    end else if (state == ST_ROUND2) begin
      yhist[{sec, cur_ptr}] <= rnd.y;
    end
    y_rd <= yhist[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      bmem[clr_cnt] <= '0;
    end else if (coef_acc && sec_ok && idx_ok && coef_kind == KIND_FF) begin
      bmem[coef_waddr] <= coef_value;
    end
    b_rd <= bmem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      amem[clr_cnt] <= '0;
    end else if (coef_acc && sec_ok && idx_ok && coef_kind == KIND_FB) begin
      amem[coef_waddr] <= coef_value;
    end
    a_rd <= amem[coef_raddr];
  end

  // operand select for the shared multiplier
  assign mac_op = tag_q.op;

  always_comb begin
    case (tag_q.sel)
      SEL_FF: begin
        mac_a = OPA_W'(x_rd);
        mac_b = b_rd;
      end
      SEL_FB: begin
        mac_a = OPA_W'(y_rd);
        mac_b = a_rd;
      end
      SEL_LO: begin
        mac_a = $signed({{(OPA_W - FRAC_SH){1'b0}}, mid_q[FRAC_SH-1:0]});
        mac_b = recip[sec];
      end
      SEL_HI: begin
        mac_a = OPA_W'($signed(mid_q[MID_W-1:FRAC_SH]));
        mac_b = recip[sec];
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!m_tvalid && !s_tready))
    else $error("transfer possible during memory clear");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FINISH))
    else $error("result raised outside finish");

  a_filter_start: assert property (@(posedge clk) disable iff (rst)
    filt_acc |=> (state == ST_LOAD))
    else $error("accepted sample did not start a section");

  a_issue_src: assert property (@(posedge clk) disable iff (rst)
    tag_q.op.valid |-> $past(state == ST_FF || state == ST_FB ||
                             state == ST_SCALE_LO || state == ST_SCALE_HI))
    else $error("multiply issued from a non-issue state");

endmodule

// ===== rtl/cascaded_iir_filter_top.sv =====
// channel  dir  tdata (low bit up)                         tuser (low bit up)
// s_*      in   sample_in, coef_section, coef_index,       func, coef_kind
//               coef_value, 2 pad bits
// m_*      out  filtered_sample                            saturated
// cfg_*    in   cfg_index selects num_sections/feedforward_taps/feedback_taps
//
// A coefficient transfer is taken in idle and leaves s_tready high.
// A sample transfer drops s_tready until its result is loaded, so the next item is
// taken only once a sample is through the single multiply-accumulate, which walks
// every tap of every section (ns, ff, fb clamped).
// After rst the four tap memories are swept to zero, all 2**(SEC_W + TAP_W) entries
// (SEC_W at least 1; 64 by default), with s_tready low; cfg writes are taken throughout.
// The result register holds while m_tready is low; the next item is still taken.
module cascaded_iir_filter_top #(
  parameter int SECTIONS = cif_pkg::DEF_SECTIONS,
  parameter int TAPS     = cif_pkg::DEF_TAPS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cif_pkg::IN_TDATA_W-1:0]  s_tdata, // sample_in, coef_section, coef_index, coef_value
  input  logic [cif_pkg::IN_TUSER_W-1:0]  s_tuser, // func, coef_kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cif_pkg::OUT_TDATA_W-1:0] m_tdata, // filtered_sample
  output logic [cif_pkg::OUT_TUSER_W-1:0] m_tuser, // saturated
  input  logic                            cfg_we,
  input  logic [cif_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cif_pkg::CNT_REG_W-1:0]   cfg_data
);
  import cif_pkg::*;

  cfg_t    cfg;
  mac_op_t mac_op;
  rnd_t    rnd;

  logic signed [OPA_W-1:0]    mac_a;
  logic signed [COEF_W-1:0]   mac_b;
  logic signed [SAMPLE_W-1:0] filtered_sample;
  logic                       saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_sections <= CNT_REG_W'(1);
      cfg.ff_taps      <= CNT_REG_W'(3);
      cfg.fb_taps      <= CNT_REG_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_SECTIONS: cfg.num_sections <= cfg_data;
        REG_FF_TAPS:      cfg.ff_taps      <= cfg_data;
        REG_FB_TAPS:      cfg.fb_taps      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cif_ctrl #(
    .SECTIONS (SECTIONS),
    .TAPS     (TAPS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .func            (s_tuser[0]),
    .sample_in       ($signed(s_tdata[23:0])),
    .coef_kind       (s_tuser[2:1]),
    .coef_section    (s_tdata[26:24]),
    .coef_index      (s_tdata[29:27]),
    .coef_value      ($signed(s_tdata[53:30])),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .filtered_sample (filtered_sample),
    .saturated       (saturated),
    .mac_op          (mac_op),
    .mac_a           (mac_a),
    .mac_b           (mac_b),
    .rnd             (rnd)
  );

  cif_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mac_op),
    .opa (mac_a),
    .opb (mac_b),
    .rnd (rnd)
  );

  assign m_tdata = filtered_sample;
  assign m_tuser = saturated;

endmodule

// ===== tb/cascaded_iir_filter_top_test.sv =====
module cascaded_iir_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cif_pkg::*;

  localparam int NSEC = DEF_SECTIONS;
  localparam int NTAP = DEF_TAPS;
  localparam int MAX_LATENCY = 2 + NSEC * 3 * NTAP + 16;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int RANDOM_ITEMS = 1650;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int ONE_Q20 = 1 << FRAC_SH;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP = 24'sh7fffff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = 24'sh800000;

  localparam longint ROUND_HALF = longint'(1) <<< (FRAC_SH - 1);
  localparam longint MID_LIM = longint'(1) <<< (MID_W - 1);
  localparam longint Y_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint Y_MIN = -(longint'(1) <<< (SAMPLE_W - 1));

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
    logic [1:0]                 kind;
    logic [2:0]                 section;
    logic [2:0]                 tap;
    logic signed [COEF_W-1:0]   value;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sat;
  } filter_out_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_NUM_SECTIONS;
  logic [CNT_REG_W-1:0]   cfg_data = '0;

  cascaded_iir_filter_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // filter state mirror
  logic signed [SAMPLE_W-1:0] x_hist [NSEC][NTAP];
  logic signed [SAMPLE_W-1:0] y_hist [NSEC][NTAP];
  logic signed [COEF_W-1:0]   b_coef [NSEC][NTAP];
  logic signed [COEF_W-1:0]   a_coef [NSEC][NTAP];
  logic signed [COEF_W-1:0]   inv_a0 [NSEC];
  logic [CNT_REG_W-1:0]       cur_sections = 4'd1;
  logic [CNT_REG_W-1:0]       cur_ff = 4'd3;
  logic [CNT_REG_W-1:0]       cur_fb = 4'd3;

  filter_out_t expected_outputs[$];
  int          errors = 0;
  int          items_sent = 0;
  bit          idle_on = 1'b1;
  longint      cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int clamp_count(logic [CNT_REG_W-1:0] v, int top);
    if (v < 1) return 1;
    if (v > top) return top;
    return int'(v);
  endfunction

  function automatic filter_out_t filter_sample(logic signed [SAMPLE_W-1:0] x_in);
    filter_out_t r;
    int ns, ff, fb;
    longint acc, mid, y;
    logic signed [SAMPLE_W-1:0] stage;
    logic sat;
    ns = clamp_count(cur_sections, NSEC);
    ff = clamp_count(cur_ff, NTAP);
    fb = clamp_count(cur_fb, NTAP);
    stage = x_in;
    sat = 1'b0;
    for (int s = 0; s < ns; s++) begin
      for (int k = NTAP - 1; k > 0; k--) begin
        x_hist[s][k] = x_hist[s][k-1];
        y_hist[s][k] = y_hist[s][k-1];
      end
      x_hist[s][0] = stage;
      y_hist[s][0] = '0;
      acc = 0;
      for (int k = 0; k < ff; k++)
        acc += longint'(b_coef[s][k]) * longint'(x_hist[s][k]);
      for (int k = 1; k < fb; k++)
        acc -= longint'(a_coef[s][k]) * longint'(y_hist[s][k]);
      mid = (acc + ROUND_HALF) >>> FRAC_SH;
      if (mid < -MID_LIM) begin
        mid = -MID_LIM;
        sat = 1'b1;
      end else if (mid > MID_LIM - 1) begin
        mid = MID_LIM - 1;
        sat = 1'b1;
      end
      y = (mid * longint'(inv_a0[s]) + ROUND_HALF) >>> FRAC_SH;
      if (y < Y_MIN) begin
        y = Y_MIN;
        sat = 1'b1;
      end else if (y > Y_MAX) begin
        y = Y_MAX;
        sat = 1'b1;
      end
      stage = y[SAMPLE_W-1:0];
      y_hist[s][0] = stage;
    end
    r.sample = stage;
    r.sat = sat;
    return r;
  endfunction

  function automatic void store_coef(item_t it);
    case (it.kind)
      KIND_FF:    b_coef[it.section][it.tap] = it.value;
      KIND_FB:    a_coef[it.section][it.tap] = it.value;
      KIND_RECIP: inv_a0[it.section] = it.value;
      default: ;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_span(int lim);
    return 24'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic item_t sample_item(logic signed [SAMPLE_W-1:0] x);
    item_t it;
    it.func = FUNC_FILTER;
    it.sample = x;
    it.kind = 2'($urandom());
    it.section = 3'($urandom());
    it.tap = 3'($urandom());
    it.value = 24'($urandom());
    return it;
  endfunction

  function automatic item_t coef_item(logic [1:0] kind, logic [2:0] section, logic [2:0] tap,
                                      logic signed [COEF_W-1:0] value);
    item_t it;
    it.func = FUNC_COEF;
    it.sample = 24'($urandom());
    it.kind = kind;
    it.section = section;
    it.tap = tap;
    it.value = value;
    return it;
  endfunction

  function automatic item_t noise_coef_item();
    return coef_item(2'($urandom()), 3'($urandom()), 3'($urandom()), 24'($urandom()));
  endfunction

  task automatic send_item(item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, it.value, it.tap, it.section, it.sample};
    s_tuser <= {it.kind, it.func};
    do @(posedge clk); while (!s_tready);
    if (it.func == FUNC_COEF) store_coef(it);
    else expected_outputs.push_back(filter_sample(it.sample));
    if (!(it.func == FUNC_COEF && it.kind == KIND_UNUSED)) items_sent++;
  endtask

  // sender holds off until every pending result is out and the core has settled
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (MAX_LATENCY) @(posedge clk);
  endtask

  task automatic set_config(logic [CNT_REG_W-1:0] ns, logic [CNT_REG_W-1:0] ff,
                            logic [CNT_REG_W-1:0] fb);
    cfg_we <= 1'b1;
    cfg_index <= REG_NUM_SECTIONS;
    cfg_data <= ns;
    @(posedge clk);
    cfg_index <= REG_FF_TAPS;
    cfg_data <= ff;
    @(posedge clk);
    cfg_index <= REG_FB_TAPS;
    cfg_data <= fb;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_sections = ns;
    cur_ff = ff;
    cur_fb = fb;
    @(posedge clk);
  endtask

  task automatic load_section(int s, int ff, int fb, bit wild);
    logic signed [COEF_W-1:0] r;
    for (int k = 0; k < ff; k++)
      send_item(coef_item(KIND_FF, 3'(s), 3'(k),
                          wild ? 24'($urandom()) : rand_span(ONE_Q20 / (2 * ff))));
    for (int k = 0; k < fb; k++)
      send_item(coef_item(KIND_FB, 3'(s), 3'(k),
                          (wild || k == 0) ? 24'($urandom()) : rand_span(ONE_Q20 / (2 * fb))));
    if (wild) r = 24'($urandom());
    else r = 24'(int'($urandom_range(ONE_Q20 / 2, 2 * ONE_Q20)));
    if ($urandom_range(0, 3) == 0) r = -r;
    if ($urandom_range(0, 7) != 0) send_item(coef_item(KIND_RECIP, 3'(s), 3'd0, r));
  endtask

  task automatic test_unwritten_reciprocal();
    send_item(coef_item(KIND_FF, 3'd0, 3'd0, 24'(ONE_Q20)));
    send_item(sample_item(SAMPLE_TOP));
    send_item(sample_item(SAMPLE_BOTTOM));
  endtask

  task automatic test_identity_section();
    send_item(coef_item(KIND_RECIP, 3'd0, 3'd0, 24'(ONE_Q20)));
    send_item(sample_item(SAMPLE_TOP));
    send_item(sample_item(SAMPLE_BOTTOM));
    send_item(sample_item(24'sd0));
    send_item(sample_item(-24'sd1));
  endtask

  task automatic test_ignored_writes();
    send_item(coef_item(KIND_UNUSED, 3'd0, 3'd0, SAMPLE_TOP));
    send_item(coef_item(KIND_FB, 3'd0, 3'd0, SAMPLE_BOTTOM));
    send_item(sample_item(24'sd12345));
  endtask

  task automatic test_saturation();
    send_item(coef_item(KIND_FF, 3'd0, 3'd0, SAMPLE_TOP));
    send_item(sample_item(SAMPLE_TOP));
    send_item(sample_item(SAMPLE_BOTTOM));
    send_item(coef_item(KIND_RECIP, 3'd0, 3'd0, SAMPLE_BOTTOM));
    send_item(sample_item(24'sd1000));
    send_item(sample_item(SAMPLE_BOTTOM));
  endtask

  task automatic test_feedback_path();
    wait_for_results();
    set_config(4'd1, 4'd1, 4'd2);
    send_item(coef_item(KIND_FF, 3'd0, 3'd0, 24'(ONE_Q20)));
    send_item(coef_item(KIND_RECIP, 3'd0, 3'd0, 24'(ONE_Q20)));
    send_item(coef_item(KIND_FB, 3'd0, 3'd1, 24'(-(ONE_Q20 / 2))));
    send_item(sample_item(24'sh400000));
    send_item(sample_item(24'sd0));
    send_item(sample_item(24'sd0));
  endtask

  task automatic test_random_phases();
    int ns, ff, fb, n_samples;
    bit wild;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_for_results();
      case ($urandom_range(0, 11))
        0: set_config(4'd0, 4'd0, 4'd0);
        1: set_config(4'd15, 4'd15, 4'd15);
        2: set_config(CNT_REG_W'(NSEC), CNT_REG_W'(NTAP), CNT_REG_W'(NTAP));
        3: set_config(4'd1, 4'd1, 4'd1);
        4: set_config(4'($urandom()), 4'($urandom()), 4'($urandom()));
        default: set_config(4'($urandom_range(1, 3)), 4'($urandom_range(1, 4)),
                            4'($urandom_range(1, 4)));
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      wild = ($urandom_range(0, 4) == 0);
      ns = clamp_count(cur_sections, NSEC);
      ff = clamp_count(cur_ff, NTAP);
      fb = clamp_count(cur_fb, NTAP);
      for (int s = 0; s < ns; s++) load_section(s, ff, fb, wild);
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 4)) send_item(noise_coef_item());
      n_samples = $urandom_range(8, 40);
      for (int i = 0; i < n_samples; i++) begin
        if ($urandom_range(0, 19) == 0) send_item(noise_coef_item());
        else if ($urandom_range(0, 2) == 0) send_item(sample_item(rand_span(1 << 20)));
        else send_item(sample_item(24'($urandom())));
      end
    end
  endtask

  initial begin
    @(posedge clk);
    forever begin
      int stall;
      stall = idle_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    filter_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_outputs.size() == 0) begin
        $error("unexpected transfer: filtered_sample %0d saturated %0d",
               $signed(m_tdata), m_tuser[0]);
        errors++;
      end else begin
        want = expected_outputs.pop_front();
        if (m_tdata !== want.sample) begin
          $error("filtered_sample: expected %0d, actual %0d", want.sample, $signed(m_tdata));
          errors++;
        end
        if (m_tuser[0] !== want.sat) begin
          $error("saturated: expected %0d, actual %0d", want.sat, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NSEC; s++) begin
      inv_a0[s] = '0;
      for (int k = 0; k < NTAP; k++) begin
        x_hist[s][k] = '0;
        y_hist[s][k] = '0;
        b_coef[s][k] = '0;
        a_coef[s][k] = '0;
      end
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_unwritten_reciprocal();
    test_identity_section();
    test_ignored_writes();
    test_saturation();
    test_feedback_path();
    test_random_phases();
    wait_for_results();
    if (errors == 0 && expected_outputs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
